@@ sv/vic_pkg.sv @@
// ----------------------------------------------------------------------------
// vic_pkg
// Shared types, constants and color tables for the vegetation index
// classifier.
// ----------------------------------------------------------------------------
package vic_pkg;

   // Width of one pixel intensity field.
   localparam int PIXEL_BITS = 8;
   // Signed width of the numerator, the denominator and the scaled compares.
   localparam int CALC_BITS  = PIXEL_BITS + 8;

   localparam int MODE_BITS  = 2;
   localparam int CLASS_BITS = 3;
   localparam int COLOR_BITS = 8;

   localparam logic [MODE_BITS-1:0] MODE_ARVI = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_EVI  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_SAVI = 2'd2;

   localparam logic [CLASS_BITS-1:0] CLASS_BARE   = 3'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_SPARSE = 3'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_MODEST = 3'd2;
   localparam logic [CLASS_BITS-1:0] CLASS_DENSE  = 3'd3;
   localparam logic [CLASS_BITS-1:0] CLASS_LUSH   = 3'd4;

   typedef logic [MODE_BITS-1:0] mode_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] nir;
      logic [PIXEL_BITS-1:0] red;
      logic [PIXEL_BITS-1:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [CLASS_BITS-1:0] health_class;
      logic [COLOR_BITS-1:0] out_green;
      logic [COLOR_BITS-1:0] out_red;
   } rsp_payload_type;

   function automatic logic [COLOR_BITS-1:0] green_of_class(
      input logic [CLASS_BITS-1:0] cls
   );
      logic [COLOR_BITS-1:0] g;
      unique case (cls)
         CLASS_BARE:   g = 8'd0;
         CLASS_SPARSE: g = 8'd128;
         CLASS_MODEST: g = 8'd255;
         CLASS_DENSE:  g = 8'd255;
         CLASS_LUSH:   g = 8'd128;
         default:      g = 8'd0;
      endcase
      return g;
   endfunction

   function automatic logic [COLOR_BITS-1:0] red_of_class(
      input logic [CLASS_BITS-1:0] cls
   );
      logic [COLOR_BITS-1:0] r;
      unique case (cls)
         CLASS_BARE:   r = 8'd255;
         CLASS_SPARSE: r = 8'd255;
         CLASS_MODEST: r = 8'd255;
         CLASS_DENSE:  r = 8'd0;
         CLASS_LUSH:   r = 8'd0;
         default:      r = 8'd0;
      endcase
      return r;
   endfunction

endpackage

@@ sv/vegetation_index_classifier.sv @@
// ----------------------------------------------------------------------------
// vegetation_index_classifier
// Per-pixel ARVI, EVI or SAVI computation and five-bin health classification.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one pixel item (nir, red, blue) per accepted
//   cycle; the rsp channel returns one item (health_class and its color)
//   for each pixel, in order. Both channels use valid and stall: an item
//   moves on a clock edge where valid is high and stall is low.
//   The csr channel writes index_mode (0 ARVI, 1 EVI, 2 SAVI, 3 as SAVI);
//   it is always ready and is to be written only while no pixel is in flight.
//   rsp_valid rises once an accepted pixel moves on from the input
//   register to the result register: one input register, then the index
//   arithmetic and bin compares feed the result register. Throughput is
//   one pixel per clock while the receiver does not stall; it is set by
//   the single pass of constant shifts, adds, two zero tests and four bin
//   compares between the two registers.
//   When the receiver stalls, the result register holds its item; an empty
//   input register still takes one more pixel, and then req_stall rises.
//   A synchronous reset empties both registers and sets index_mode to ARVI.
// ----------------------------------------------------------------------------
module vegetation_index_classifier (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  vic_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output vic_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  vic_pkg::mode_type        csr_data
);

   localparam int W = vic_pkg::CALC_BITS;

   vic_pkg::mode_type        mode_ff;
   logic                     in_valid_ff;
   vic_pkg::req_payload_type in_data_ff;
   logic                     out_valid_ff;
   vic_pkg::rsp_payload_type out_data_ff;

   logic                     out_take;
   logic                     in_take;

   logic signed [W-1:0]      n_s, r_s, b_s, diff_s;
   logic signed [W-1:0]      num_s, den_s, num_n, den_n;
   logic signed [W-1:0]      num_x4, den_x2, den_x3;
   logic [vic_pkg::CLASS_BITS-1:0] cls;
   vic_pkg::rsp_payload_type out_data_in;

   assign csr_ready = 1'b1;

   // The result register loads whenever it is empty or its item leaves.
   assign out_take  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_take;
   assign in_take   = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign n_s    = signed'(W'(in_data_ff.nir));
   assign r_s    = signed'(W'(in_data_ff.red));
   assign b_s    = signed'(W'(in_data_ff.blue));
   assign diff_s = n_s - r_s;

   always_comb begin
      unique case (mode_ff)
         vic_pkg::MODE_ARVI: begin
            num_s = n_s - (r_s <<< 1) + b_s;
            den_s = n_s + (r_s <<< 1) + b_s;
         end
         vic_pkg::MODE_EVI: begin
            // 2.5(N-R)/(N+6R-4.5B+1) scaled by two on both terms.
            num_s = (diff_s <<< 2) + diff_s;
            den_s = (n_s <<< 1) + (r_s <<< 3) + (r_s <<< 2)
                    - (b_s <<< 3) - b_s + signed'(W'(2));
         end
         default: begin
            num_s = (diff_s <<< 1) + diff_s;
            den_s = n_s + r_s + signed'(W'(2));
         end
      endcase
   end

   // Make the denominator positive so that v <= k/4 becomes 4*num <= k*den.
   always_comb begin
      if (den_s < 0) begin
         num_n = -num_s;
         den_n = -den_s;
      end else begin
         num_n = num_s;
         den_n = den_s;
      end
      num_x4 = num_n <<< 2;
      den_x2 = den_n <<< 1;
      den_x3 = den_x2 + den_n;
   end

   always_comb begin
      priority if (den_s == 0) begin
         cls = (num_s < 0) ? vic_pkg::CLASS_BARE : vic_pkg::CLASS_LUSH;
      end else if (num_x4 <= 0) begin
         cls = vic_pkg::CLASS_BARE;
      end else if (num_x4 <= den_n) begin
         cls = vic_pkg::CLASS_SPARSE;
      end else if (num_x4 <= den_x2) begin
         cls = vic_pkg::CLASS_MODEST;
      end else if (num_x4 <= den_x3) begin
         cls = vic_pkg::CLASS_DENSE;
      end else begin
         cls = vic_pkg::CLASS_LUSH;
      end
      out_data_in.health_class = cls;
      out_data_in.out_green    = vic_pkg::green_of_class(cls);
      out_data_in.out_red      = vic_pkg::red_of_class(cls);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= vic_pkg::MODE_ARVI;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         if (in_take) begin
            in_valid_ff <= 1'b1;
         end else if (out_take) begin
            in_valid_ff <= 1'b0;
         end
         if (out_take) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff <= req_data;
      end
      if (out_take && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

@@ sv/vic_checker.sv @@
// ----------------------------------------------------------------------------
// vic_checker
// Port-level checks for the vegetation index classifier, bound to the top.
// ----------------------------------------------------------------------------
module vic_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input vic_pkg::rsp_payload_type rsp_data
);

   // A result held by the receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or vanished");

   // An accepted pixel must leave a result waiting once it has passed the input and result registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("accepted item did not reach the result register");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.health_class <= vic_pkg::CLASS_LUSH)
      else $error("health class out of range");

   // The color must follow the class.
   a_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.out_green == vic_pkg::green_of_class(rsp_data.health_class)
         && rsp_data.out_red == vic_pkg::red_of_class(rsp_data.health_class))
      else $error("result color does not match its class");

endmodule

bind vegetation_index_classifier vic_checker u_vic_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
